// File: src/qto_pkg.sv
package qto_pkg;

	localparam int QTO_CORDIC_STEPS = 16;
	localparam int QTO_ATAN_LEN     = 24;
	localparam int QTO_DPT_W        = 24;
	localparam int QTO_COUNT_W      = 16;
	localparam int QTO_ANGLE_W      = 16;
	localparam int QTO_TOTAL_W      = 32;
	localparam int QTO_POS_W        = 32;

	localparam logic [QTO_DPT_W-1:0] QTO_DPT_RESET = 24'd16777;

	// cordic gain in Q1.30
	localparam logic signed [33:0] QTO_CORDIC_GAIN = 34'sd652032874;

	typedef enum logic [1:0] {
		KIND_SAMPLE   = 2'd0,
		KIND_ODOM     = 2'd1,
		KIND_POSE_CLR = 2'd2,
		KIND_TICK_CLR = 2'd3
	} kind_t;

	// atan(2^-i) as a 32-bit binary angle
	function automatic logic [29:0] qto_atan(input logic [4:0] idx);
		logic [29:0] v;
		case (idx)
			5'd0:  v = 30'd536870912;
			5'd1:  v = 30'd316933406;
			5'd2:  v = 30'd167458907;
			5'd3:  v = 30'd85004756;
			5'd4:  v = 30'd42667331;
			5'd5:  v = 30'd21354465;
			5'd6:  v = 30'd10679838;
			5'd7:  v = 30'd5340245;
			5'd8:  v = 30'd2670163;
			5'd9:  v = 30'd1335087;
			5'd10: v = 30'd667544;
			5'd11: v = 30'd333772;
			5'd12: v = 30'd166886;
			5'd13: v = 30'd83443;
			5'd14: v = 30'd41722;
			5'd15: v = 30'd20861;
			5'd16: v = 30'd10430;
			5'd17: v = 30'd5215;
			5'd18: v = 30'd2608;
			5'd19: v = 30'd1304;
			5'd20: v = 30'd652;
			5'd21: v = 30'd326;
			5'd22: v = 30'd163;
			5'd23: v = 30'd81;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

// File: src/qto_ev_if.sv
interface qto_ev_if;
	import qto_pkg::*;

	logic                          valid;
	logic                          ready;
	logic [1:0]                    kind;
	logic [QTO_COUNT_W-1:0]        left_count;
	logic [QTO_COUNT_W-1:0]        right_count;
	logic signed [QTO_ANGLE_W-1:0] heading;

	modport source (output valid, kind, left_count, right_count, heading, input ready);
	modport sink (input valid, kind, left_count, right_count, heading, output ready);
endinterface

// File: src/qto_res_if.sv
interface qto_res_if;
	import qto_pkg::*;

	logic                          valid;
	logic                          ready;
	logic signed [QTO_TOTAL_W-1:0] left_total;
	logic signed [QTO_TOTAL_W-1:0] right_total;
	logic signed [QTO_COUNT_W-1:0] left_step;
	logic signed [QTO_COUNT_W-1:0] right_step;
	logic signed [QTO_POS_W-1:0]   pos_x;
	logic signed [QTO_POS_W-1:0]   pos_y;
	logic signed [QTO_ANGLE_W-1:0] held_heading;

	modport source (output valid, left_total, right_total, left_step, right_step, pos_x,
		pos_y, held_heading, input ready);
	modport sink (input valid, left_total, right_total, left_step, right_step, pos_x,
		pos_y, held_heading, output ready);
endinterface

// File: src/qto_cfg_if.sv
interface qto_cfg_if;
	import qto_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [QTO_DPT_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// File: src/quadrature_tick_odometry_unit.sv
// sample and clear events: accept goes straight to ST_DONE, which loads the result
// odometry events: serial cordic loop, ST_RND, four partial products through the
//   shared 34x25 multiplier that also forms the distance product, then ST_SAT
// one event in flight: next beat taken once the result is in the output register;
//   ST_DONE holds while the output register is full and not taken
// reset: arst_n clears all pose, tick and handshake state; distance_per_tick to 16777
module quadrature_tick_odometry_unit #(
	parameter int CORDIC_STEPS = qto_pkg::QTO_CORDIC_STEPS
) (
	input  logic   clk,
	input  logic   arst_n,
	qto_ev_if.sink   ev,
	qto_res_if.source res,
	qto_cfg_if.sink  cfg
);
	import qto_pkg::*;

	localparam int CNT_W = $clog2(CORDIC_STEPS);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CORDIC_STEPS - 1);

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_CORD = 10'b0000000010,
		ST_RND  = 10'b0000000100,
		ST_MXL  = 10'b0000001000,
		ST_MXH  = 10'b0000010000,
		ST_MYL  = 10'b0000100000,
		ST_MYH  = 10'b0001000000,
		ST_INCY = 10'b0010000000,
		ST_SAT  = 10'b0100000000,
		ST_DONE = 10'b1000000000
	} state_t;

	state_t state_q;

	logic [QTO_DPT_W-1:0]          dpt_q;
	logic [QTO_COUNT_W-1:0]        prev_l_q, prev_r_q;
	logic [QTO_TOTAL_W-1:0]        sum_l_q, sum_r_q, owed_l_q, owed_r_q;
	logic [QTO_COUNT_W-1:0]        step_l_q, step_r_q;
	logic signed [QTO_POS_W-1:0]   x_q, y_q;
	logic signed [QTO_ANGLE_W-1:0] angle_q, head_q;

	logic signed [33:0] cx_q, cy_q, cz_q;
	logic               flip_q;
	logic [CNT_W-1:0]   cnt_q;

	logic signed [21:0] cos_q, sin_q;
	logic signed [43:0] dist_q;
	logic signed [58:0] prod_q, lo_q;
	logic signed [34:0] inc_x_q, inc_y_q;

	logic                          out_vld_q;
	logic [QTO_TOTAL_W-1:0]        o_sum_l_q, o_sum_r_q;
	logic [QTO_COUNT_W-1:0]        o_step_l_q, o_step_r_q;
	logic signed [QTO_POS_W-1:0]   o_x_q, o_y_q;
	logic signed [QTO_ANGLE_W-1:0] o_ang_q;

	logic ev_acc;
	logic out_free;
	assign ev.ready = (state_q == ST_IDLE);
	assign ev_acc   = ev.valid && ev.ready;
	assign out_free = !out_vld_q || res.ready;
	assign cfg.ready = 1'b1;

	// shared multiplier
	logic signed [33:0] mul_a;
	logic signed [24:0] mul_b;
	logic signed [58:0] mul_p;
	logic signed [33:0] owed_sum;
	logic signed [33:0] d_lo, d_hi;

	assign owed_sum = 34'(signed'(owed_l_q)) + 34'(signed'(owed_r_q));
	assign d_lo = $signed({12'b0, dist_q[21:0]});
	assign d_hi = 34'(signed'(dist_q[43:22]));

	always_comb begin
		mul_a = owed_sum;
		mul_b = $signed({1'b0, dpt_q});
		case (state_q)
			ST_MXL: begin
				mul_a = d_lo;
				mul_b = 25'(cos_q);
			end
			ST_MXH: begin
				mul_a = d_hi;
				mul_b = 25'(cos_q);
			end
			ST_MYL: begin
				mul_a = d_lo;
				mul_b = 25'(sin_q);
			end
			ST_MYH: begin
				mul_a = d_hi;
				mul_b = 25'(sin_q);
			end
			default: begin
				mul_a = owed_sum;
				mul_b = $signed({1'b0, dpt_q});
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// (hi << 22) + lo, then floor shift by 29
	function automatic logic signed [34:0] combine(input logic signed [58:0] hi,
		input logic signed [58:0] lo);
		logic signed [63:0] acc;
		acc = (64'(hi) <<< 22) + 64'(lo);
		return acc[63:29];
	endfunction

	function automatic logic signed [31:0] sat_add(input logic signed [31:0] pos,
		input logic signed [34:0] inc);
		logic signed [35:0] r;
		r = 36'(pos) + 36'(inc);
		if (r > 36'sh07FFFFFFF) begin
			return 32'sh7FFFFFFF;
		end else if (r < -36'sh080000000) begin
			return 32'sh80000000;
		end
		return r[31:0];
	endfunction

	// cordic step
	logic signed [33:0] dx, dy, atan_v;
	assign dx = cx_q >>> cnt_q;
	assign dy = cy_q >>> cnt_q;
	assign atan_v = $signed({4'b0, qto_atan(5'(cnt_q))});

	// cordic init from the incoming heading
	logic                          big;
	logic signed [QTO_ANGLE_W-1:0] ang_in;
	assign big    = (ev.heading > 16'sd16384) || (ev.heading < -16'sd16384);
	assign ang_in = big ? {~ev.heading[15], ev.heading[14:0]} : ev.heading;

	logic signed [33:0] rx, ry;
	assign rx = (cx_q + 34'sd512) >>> 10;
	assign ry = (cy_q + 34'sd512) >>> 10;

	logic [QTO_COUNT_W-1:0] dl, dr;
	assign dl = ev.left_count - prev_l_q;
	assign dr = ev.right_count - prev_r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dpt_q <= QTO_DPT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			dpt_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			prev_l_q  <= '0;
			prev_r_q  <= '0;
			sum_l_q   <= '0;
			sum_r_q   <= '0;
			owed_l_q  <= '0;
			owed_r_q  <= '0;
			step_l_q  <= '0;
			step_r_q  <= '0;
			x_q       <= '0;
			y_q       <= '0;
			angle_q   <= '0;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (res.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (ev_acc) begin
						state_q <= ST_DONE;
						case (kind_t'(ev.kind))
							KIND_SAMPLE: begin
								step_l_q <= dl;
								step_r_q <= dr;
								sum_l_q  <= sum_l_q + 32'(signed'(dl));
								sum_r_q  <= sum_r_q + 32'(signed'(dr));
								owed_l_q <= owed_l_q + 32'(signed'(dl));
								owed_r_q <= owed_r_q + 32'(signed'(dr));
								prev_l_q <= ev.left_count;
								prev_r_q <= ev.right_count;
							end
							KIND_ODOM: begin
								cnt_q   <= '0;
								state_q <= ST_CORD;
							end
							KIND_POSE_CLR: begin
								owed_l_q <= '0;
								owed_r_q <= '0;
								x_q      <= '0;
								y_q      <= '0;
								angle_q  <= '0;
							end
							default: begin
								prev_l_q <= '0;
								prev_r_q <= '0;
								sum_l_q  <= '0;
								sum_r_q  <= '0;
								step_l_q <= '0;
								step_r_q <= '0;
								owed_l_q <= '0;
								owed_r_q <= '0;
							end
						endcase
					end
				end
				ST_CORD: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_STEP) begin
						state_q <= ST_RND;
					end
				end
				ST_RND: begin
					owed_l_q <= '0;
					owed_r_q <= '0;
					angle_q  <= head_q;
					state_q  <= ST_MXL;
				end
				ST_MXL:  state_q <= ST_MXH;
				ST_MXH:  state_q <= ST_MYL;
				ST_MYL:  state_q <= ST_MYH;
				ST_MYH:  state_q <= ST_INCY;
				ST_INCY: state_q <= ST_SAT;
				ST_SAT: begin
					x_q     <= sat_add(x_q, inc_x_q);
					y_q     <= sat_add(y_q, inc_y_q);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_vld_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		case (state_q)
			ST_IDLE: begin
				head_q <= ev.heading;
				flip_q <= big;
				cx_q   <= QTO_CORDIC_GAIN;
				cy_q   <= '0;
				cz_q   <= {{2{ang_in[15]}}, ang_in, 16'b0};
			end
			ST_CORD: begin
				if (!cz_q[33]) begin
					cx_q <= cx_q - dy;
					cy_q <= cy_q + dx;
					cz_q <= cz_q - atan_v;
				end else begin
					cx_q <= cx_q + dy;
					cy_q <= cy_q - dx;
					cz_q <= cz_q + atan_v;
				end
			end
			ST_RND: begin
				cos_q <= flip_q ? -rx[21:0] : rx[21:0];
				sin_q <= flip_q ? -ry[21:0] : ry[21:0];
				// distance product sits in prod_q since the cordic loop
				if (prod_q > 59'sd4398046511104) begin
					dist_q <= 44'sd4398046511104;
				end else if (prod_q < -59'sd4398046511104) begin
					dist_q <= -44'sd4398046511104;
				end else begin
					dist_q <= prod_q[43:0];
				end
			end
			ST_MXH: lo_q <= prod_q;
			ST_MYL: inc_x_q <= combine(prod_q, lo_q);
			ST_MYH: lo_q <= prod_q;
			ST_INCY: inc_y_q <= combine(prod_q, lo_q);
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			o_sum_l_q  <= sum_l_q;
			o_sum_r_q  <= sum_r_q;
			o_step_l_q <= step_l_q;
			o_step_r_q <= step_r_q;
			o_x_q      <= x_q;
			o_y_q      <= y_q;
			o_ang_q    <= angle_q;
		end
	end

	assign res.valid        = out_vld_q;
	assign res.left_total   = signed'(o_sum_l_q);
	assign res.right_total  = signed'(o_sum_r_q);
	assign res.left_step    = signed'(o_step_l_q);
	assign res.right_step   = signed'(o_step_r_q);
	assign res.pos_x        = o_x_q;
	assign res.pos_y        = o_y_q;
	assign res.held_heading = o_ang_q;

	a_odom_starts_cordic: assert property (@(posedge clk) disable iff (!arst_n)
		ev_acc && ev.kind == KIND_ODOM |=> state_q == ST_CORD && cnt_q == '0)
		else $error("odometry beat did not start the cordic loop");

	a_other_kinds_done: assert property (@(posedge clk) disable iff (!arst_n)
		ev_acc && ev.kind != KIND_ODOM |=> state_q == ST_DONE)
		else $error("non-odometry beat did not finish at once");

	a_cordic_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RND |-> $past(state_q) == ST_CORD && $past(cnt_q) == LAST_STEP)
		else $error("cordic loop left early");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && out_free |=> out_vld_q && state_q == ST_IDLE)
		else $error("finished event did not reach the output register");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !ev_acc)
		else $error("beat accepted while busy");
endmodule
